/* hw/rtl/ple_pkg.sv */
package ple_pkg;

	localparam int CMD_W      = 3;
	localparam int DATA_W     = 32;
	localparam int VAL_W      = 31;
	localparam int POS_W      = 8;
	localparam int SMALL_W    = 5;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	// two-entry command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD  = 2'd0;
	localparam logic [VAL_W-1:0]      THRESHOLD_RESET = 31'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_READ   = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_SEARCH = 3'd3,
		CMD_SCAN   = 3'd4,
		CMD_DUMP   = 3'd5
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_BADVAL   = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	// classified command as it waits in the queue
	typedef struct packed {
		cmd_code_t        op;
		logic             neg;
		logic [VAL_W-1:0] mag;
		logic [POS_W-1:0] pos;
	} ple_item_t;

endpackage

/* hw/rtl/ple_cmd_if.sv */
interface ple_cmd_if;
	import ple_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output command, output value, output position, input ready);
	modport sink (input valid, input command, input value, input position, output ready);

endinterface

/* hw/rtl/ple_res_if.sv */
interface ple_res_if;
	import ple_pkg::*;

	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [SMALL_W-1:0] position_out;
	logic [VAL_W-1:0]   value_out;
	logic [SMALL_W-1:0] count_out;
	logic               last;

	modport source (output valid, output status, output position_out, output value_out,
		output count_out, output last, input ready);
	modport sink (input valid, input status, input position_out, input value_out,
		input count_out, input last, output ready);

endinterface

/* hw/rtl/ple_front.sv */
module ple_front (
	ple_cmd_if.sink            cmd,
	input  logic               q_full,
	output logic               q_push,
	output ple_pkg::ple_item_t q_item
);
	import ple_pkg::*;

	logic legal;

	// undefined command codes are taken and dropped
	always_comb begin
		unique case (cmd.command) inside
			CMD_INSERT, CMD_READ, CMD_REMOVE, CMD_SEARCH, CMD_SCAN, CMD_DUMP: legal = 1'b1;
			default: legal = 1'b0;
		endcase
	end

	always_comb begin
		q_item.op  = cmd_code_t'(cmd.command);
		q_item.neg = cmd.value[DATA_W-1];
		q_item.mag = cmd.value[VAL_W-1:0];
		q_item.pos = cmd.position;
	end

	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full && legal;

endmodule

/* hw/rtl/ple_queue.sv */
module ple_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ple_pkg::ple_item_t item_in,
	output logic               full,
	input  logic               pop,
	output ple_pkg::ple_item_t item_out,
	output logic               empty
);
	import ple_pkg::*;

	ple_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full     = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign item_out = slot_q[rd_ptr_q];

	// depth is a power of two, pointers wrap by themselves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

/* hw/rtl/ple_back.sv */
module ple_back #(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  ple_pkg::ple_item_t        q_item,
	output logic                      q_pop,
	input  logic [ple_pkg::VAL_W-1:0] threshold,
	ple_res_if.source                 res
);
	import ple_pkg::*;

	localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW = $clog2(CAPACITY + 1);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_DECIDE  = 11'b00000000010,
		S_RD_DONE = 11'b00000000100,
		S_INS_RD  = 11'b00000001000,
		S_INS_WR  = 11'b00000010000,
		S_RM_GONE = 11'b00000100000,
		S_RM_RD   = 11'b00001000000,
		S_RM_WR   = 11'b00010000000,
		S_WALK    = 11'b00100000000,
		S_CHECK   = 11'b01000000000,
		S_EMIT    = 11'b10000000000
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [SMALL_W-1:0] pos;
		logic [VAL_W-1:0]   val;
		logic [SMALL_W-1:0] cnt;
		logic               last;
	} ple_res_t;

	function automatic ple_res_t mk_res(status_t st, logic [SMALL_W-1:0] p,
		logic [VAL_W-1:0] v, logic [SMALL_W-1:0] c, logic l);
		ple_res_t r;
		r.status = st;
		r.pos    = p;
		r.val    = v;
		r.cnt    = c;
		r.last   = l;
		return r;
	endfunction

	state_t           state_q;
	state_t           ret_q;
	cmd_code_t        op_q;
	logic             neg_q;
	logic [VAL_W-1:0] mag_q;
	logic [POS_W-1:0] pos_q;
	logic [CNTW-1:0]  idx_q;
	logic [CNTW-1:0]  hits_q;
	logic [CNTW-1:0]  count_q;
	logic [VAL_W-1:0] gone_q;
	ple_res_t         pend_q;
	ple_res_t         res_q;
	logic             res_valid_q;

	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rdata_q;
	logic             mem_re;
	logic [IDXW-1:0]  mem_raddr;
	logic             mem_we;
	logic [IDXW-1:0]  mem_waddr;
	logic [VAL_W-1:0] mem_wdata;

	logic               out_free;
	logic               pos_live;
	logic               pos_le;
	logic               walk_go;
	logic [CNTW-1:0]    pos_c;
	logic [CNTW-1:0]    idx_inc;
	logic [CNTW-1:0]    idx_dec;
	logic [CNTW-1:0]    count_inc;
	logic [CNTW-1:0]    count_dec;
	logic [SMALL_W-1:0] cnt_s;

	assign out_free  = !res_valid_q || res.ready;
	assign pos_live  = pos_q < POS_W'(count_q);
	assign pos_le    = pos_q <= POS_W'(count_q);
	assign pos_c     = pos_q[CNTW-1:0];
	assign idx_inc   = idx_q + CNTW'(1);
	assign idx_dec   = idx_q - CNTW'(1);
	assign count_inc = count_q + CNTW'(1);
	assign count_dec = count_q - CNTW'(1);
	assign cnt_s     = SMALL_W'(count_q);
	assign walk_go   = (idx_q < count_q) && !(op_q == CMD_SEARCH && neg_q);
	assign q_pop     = (state_q == S_IDLE) && !q_empty;

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (state_q) inside
			S_DECIDE: begin
				if ((op_q == CMD_READ || op_q == CMD_REMOVE) && pos_live) begin
					mem_re    = 1'b1;
					mem_raddr = pos_q[IDXW-1:0];
				end
			end
			S_INS_RD: begin
				if (idx_q > pos_c) begin
					mem_re    = 1'b1;
					mem_raddr = idx_dec[IDXW-1:0];
				end else begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[IDXW-1:0];
					mem_wdata = mag_q;
				end
			end
			S_INS_WR, S_RM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[IDXW-1:0];
				mem_wdata = rdata_q;
			end
			S_RM_RD: begin
				if (idx_inc < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_inc[IDXW-1:0];
				end
			end
			S_WALK: begin
				if (walk_go) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[IDXW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			op_q    <= CMD_INSERT;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			pos_q   <= '0;
			idx_q   <= '0;
			hits_q  <= '0;
			count_q <= '0;
			gone_q  <= '0;
			pend_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						op_q    <= q_item.op;
						neg_q   <= q_item.neg;
						mag_q   <= q_item.mag;
						pos_q   <= q_item.pos;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					ret_q <= S_IDLE;
					unique case (op_q) inside
						CMD_INSERT: begin
							if (count_q == CNTW'(CAPACITY)) begin
								pend_q  <= mk_res(ST_FULL, '0, '0, cnt_s, 1'b1);
								state_q <= S_EMIT;
							end else if (!pos_le) begin
								pend_q  <= mk_res(ST_BADPOS, '0, '0, cnt_s, 1'b1);
								state_q <= S_EMIT;
							end else if (neg_q) begin
								pend_q  <= mk_res(ST_BADVAL, '0, '0, cnt_s, 1'b1);
								state_q <= S_EMIT;
							end else begin
								idx_q   <= count_q;
								state_q <= S_INS_RD;
							end
						end
						CMD_READ, CMD_REMOVE: begin
							if (!pos_live) begin
								pend_q  <= mk_res(ST_BADPOS, '0, '0, cnt_s, 1'b1);
								state_q <= S_EMIT;
							end else if (op_q == CMD_READ) begin
								state_q <= S_RD_DONE;
							end else begin
								state_q <= S_RM_GONE;
							end
						end
						CMD_SEARCH, CMD_SCAN: begin
							idx_q   <= '0;
							hits_q  <= '0;
							state_q <= S_WALK;
						end
						CMD_DUMP: begin
							if (count_q == '0) begin
								pend_q  <= mk_res(ST_EMPTY, '0, '0, '0, 1'b1);
								state_q <= S_EMIT;
							end else begin
								idx_q   <= '0;
								state_q <= S_WALK;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_RD_DONE: begin
					pend_q  <= mk_res(ST_OK, SMALL_W'(pos_q), rdata_q, cnt_s, 1'b1);
					ret_q   <= S_IDLE;
					state_q <= S_EMIT;
				end
				S_INS_RD: begin
					if (idx_q > pos_c) begin
						state_q <= S_INS_WR;
					end else begin
						count_q <= count_inc;
						pend_q  <= mk_res(ST_OK, SMALL_W'(pos_q), mag_q,
							SMALL_W'(count_inc), 1'b1);
						ret_q   <= S_IDLE;
						state_q <= S_EMIT;
					end
				end
				S_INS_WR: begin
					idx_q   <= idx_dec;
					state_q <= S_INS_RD;
				end
				S_RM_GONE: begin
					gone_q  <= rdata_q;
					idx_q   <= pos_c;
					state_q <= S_RM_RD;
				end
				S_RM_RD: begin
					if (idx_inc < count_q) begin
						state_q <= S_RM_WR;
					end else begin
						count_q <= count_dec;
						pend_q  <= mk_res(ST_OK, SMALL_W'(pos_q), gone_q,
							SMALL_W'(count_dec), 1'b1);
						ret_q   <= S_IDLE;
						state_q <= S_EMIT;
					end
				end
				S_RM_WR: begin
					idx_q   <= idx_inc;
					state_q <= S_RM_RD;
				end
				S_WALK: begin
					if (walk_go) begin
						state_q <= S_CHECK;
					end else begin
						if (op_q == CMD_SCAN) begin
							pend_q <= mk_res(ST_OK, '0, '0, SMALL_W'(hits_q), 1'b1);
						end else begin
							pend_q <= mk_res(ST_NOTFOUND, '0, '0, cnt_s, 1'b1);
						end
						ret_q   <= S_IDLE;
						state_q <= S_EMIT;
					end
				end
				S_CHECK: begin
					idx_q <= idx_inc;
					unique case (op_q)
						CMD_SEARCH: begin
							if (rdata_q == mag_q) begin
								pend_q  <= mk_res(ST_OK, SMALL_W'(idx_q), mag_q, cnt_s, 1'b1);
								ret_q   <= S_IDLE;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_WALK;
							end
						end
						CMD_SCAN: begin
							if (rdata_q > threshold) begin
								hits_q  <= hits_q + CNTW'(1);
								pend_q  <= mk_res(ST_OK, SMALL_W'(idx_q), rdata_q, cnt_s, 1'b0);
								ret_q   <= S_WALK;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_WALK;
							end
						end
						CMD_DUMP: begin
							pend_q  <= mk_res(ST_OK, SMALL_W'(idx_q), rdata_q, cnt_s,
								idx_inc == count_q);
							ret_q   <= (idx_inc == count_q) ? S_IDLE : S_WALK;
							state_q <= S_EMIT;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				res_valid_q <= 1'b1;
				res_q       <= pend_q;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = res_q.status;
	assign res.position_out = res_q.pos;
	assign res.value_out    = res_q.val;
	assign res.count_out    = res_q.cnt;
	assign res.last         = res_q.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(CAPACITY))
		else $error("entry count above capacity");

	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (CNTW'(mem_raddr) < count_q))
		else $error("read of an entry that is not live");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CNTW'(mem_waddr) <= count_q))
		else $error("write beyond the end of the list");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + CNTW'(1)
			|| count_q == $past(count_q) - CNTW'(1)))
		else $error("entry count moved by more than one");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && pend_q.last) |=> state_q == S_IDLE)
		else $error("sequencer kept running after the final result");

endmodule

/* hw/rtl/positional_list_engine.sv */
// positional list engine: an ordered list of up to CAPACITY non-negative 31-bit values
// cmd channel (valid/ready): command, value, position; one transfer per command
// res channel (valid/ready): status, position_out, value_out, count_out, last;
//   every command but the undefined codes 6 and 7 yields one or more transfers,
//   the final one with last set; undefined codes are taken and dropped
// APB port: register 0 at byte address 0 holds the scan threshold (reset 10)
// commands work on the single-port entry memory and its registered read:
//   insert moves entries up one at a time, remove moves entries down one at a time,
//   search and scan visit entries from position 0, dump gives one result per entry
// a two-entry queue lets the front take commands while the back is busy,
// and the result register lets the back go on while a result waits
// reset empties the list, the queue and the result register; entry contents
// are not cleared, only entries below the count are ever read
// a stalled receiver holds the result register; the back waits with the next
// result pending and the queue fills until the cmd channel drops ready
module positional_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ple_cmd_if.sink                        cmd,
	ple_res_if.source                      res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ple_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ple_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ple_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import ple_pkg::*;

	// front to queue
	logic      q_push;
	logic      q_full;
	ple_item_t q_in;

	// queue to back
	logic      q_pop;
	logic      q_empty;
	ple_item_t q_out;

	// scan threshold register
	logic [VAL_W-1:0] threshold_q;

	// apb write completes in the access phase, no wait states
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_THRESHOLD) begin
			threshold_q <= pwdata[VAL_W-1:0];
		end
	end

	// unmapped addresses read as zero
	always_comb begin
		if (paddr == ADDR_THRESHOLD) begin
			prdata = APB_DATA_W'(threshold_q);
		end else begin
			prdata = '0;
		end
	end

	// command decode, drops undefined codes
	ple_front u_front (
		.cmd    (cmd),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_in)
	);

	// decouples command intake from list operations
	ple_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.item_out (q_out),
		.empty    (q_empty)
	);

	// list storage, shifting and walking, result register
	ple_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_out),
		.q_pop     (q_pop),
		.threshold (threshold_q),
		.res       (res)
	);

endmodule
